[src/mlpsmd_pkg.sv]
// Shared types, constants and the weight table of the stereo network saturator.
// Depends on nothing; every other file of the block uses it by scoped names.
package mlpsmd_pkg;

    localparam int CHANNELS_DEF  = 2;
    localparam int MAX_DELAY_DEF = 4096;
    localparam int LANES         = 2;
    localparam int HIDDEN        = 8;
    localparam int SW            = 24;
    localparam int FRAC          = 20;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 13;

    // weight table, in draw order: layer 1, layer 2, output layer
    localparam int WB       = 22;
    localparam int NW       = 104;
    localparam int WAW      = 7;
    localparam int L1_STRIDE = 3;
    localparam int L2_BASE  = 24;
    localparam int L2_STRIDE = 9;
    localparam int OUT_BASE = 96;

    // shared datapath widths
    localparam int MW   = 28;
    localparam int PW   = 56;
    localparam int ACCW = 64;
    localparam int QW   = 22;
    localparam int DENW = 27;
    localparam int TW   = 23;

    localparam logic [31:0] LCG_SEED = 32'h9E3779B9;
    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_ADD  = 32'd1013904223;
    localparam longint W1_SCALE = 838861;
    localparam longint W2_SCALE = 629146;
    localparam longint W3_SCALE = 419430;
    localparam longint B_SCALE  = 314573;

    typedef enum logic [CFG_IW-1:0] {
        REG_DRIVE         = 3'd0,
        REG_MIX           = 3'd1,
        REG_LATENCY       = 3'd2,
        REG_ENABLED       = 3'd3,
        REG_CHANNEL_COUNT = 3'd4
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DN_SET,
        ST_DIV,
        ST_DIV_END,
        ST_LANE,
        ST_NEUR_BIAS,
        ST_NEUR_MUL,
        ST_NEUR_ACC,
        ST_NEUR_RND,
        ST_TANH,
        ST_T_COEF,
        ST_T_MUL,
        ST_T_DIVSET,
        ST_POST,
        ST_G_MUL,
        ST_ARG_HI,
        ST_ARG_ACC_HI,
        ST_ARG_ACC_LO,
        ST_ARG_RND,
        ST_MIX_MUL,
        ST_MIX_END,
        ST_RING,
        ST_RING_OUT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_DN,
        PH_L1,
        PH_L2,
        PH_OUT,
        PH_Y
    } phase_t;

    typedef logic signed [WB-1:0] wrom_t [NW];

    function automatic logic [31:0] lcg_next(input logic [31:0] s);
        return s * LCG_MUL + LCG_ADD;
    endfunction

    function automatic logic signed [WB-1:0] scale_draw(input logic [31:0] s,
                                                        input longint k);
        logic signed [63:0] n;
        logic signed [63:0] p;
        n = $signed({32'd0, s >> 9}) - 64'sd4194304;
        p = n * k + 64'sd2097152;
        p = p >>> 22;
        return p[WB-1:0];
    endfunction

    function automatic wrom_t build_weights();
        wrom_t       w;
        logic [31:0] s;
        int          idx;
        s   = LCG_SEED;
        idx = 0;
        for (int k = 0; k < HIDDEN; k++) begin
            s = lcg_next(s); w[idx] = scale_draw(s, W1_SCALE); idx++;
            s = lcg_next(s); w[idx] = scale_draw(s, W1_SCALE); idx++;
            s = lcg_next(s); w[idx] = scale_draw(s, B_SCALE);  idx++;
        end
        for (int k = 0; k < HIDDEN; k++) begin
            for (int j = 0; j < HIDDEN; j++) begin
                s = lcg_next(s); w[idx] = scale_draw(s, W2_SCALE); idx++;
            end
            s = lcg_next(s); w[idx] = scale_draw(s, B_SCALE); idx++;
        end
        for (int k = 0; k < HIDDEN; k++) begin
            s = lcg_next(s); w[idx] = scale_draw(s, W3_SCALE); idx++;
        end
        return w;
    endfunction

    localparam wrom_t WROM = build_weights();

endpackage

[src/mlpsmd_ifs.sv]
// Valid/ready channel interfaces for input frames and delayed result frames.
// Depends on mlpsmd_pkg for the sample width.
interface mlpsmd_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [mlpsmd_pkg::SW-1:0]  left_sample;
    logic signed [mlpsmd_pkg::SW-1:0]  right_sample;

    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface mlpsmd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mlpsmd_pkg::SW-1:0]  left_out;
    logic signed [mlpsmd_pkg::SW-1:0]  right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

[src/mlp_saturator_mix_delay.sv]
// Stereo network saturator with wet/dry mix and per-lane delay ring.
// Depends on mlpsmd_pkg and the channel interfaces in mlpsmd_ifs.sv.
//
// One frame is processed at a time by a sequencer around one shared 28x28
// multiplier, a 64-bit accumulator and a restoring divider that retires one
// quotient bit per cycle. The normalized drive is a reciprocal multiplication
// on the shared multiplier, once per frame. With the block disabled or no
// lane active a frame skips the network.
// in_ch.ready is high only between frames; a finished frame waits in the
// output register while the next one is taken. After reset the rings are
// swept to zero, every address in turn, before the first frame is accepted.
module mlp_saturator_mix_delay #(
    parameter int CHANNELS  = mlpsmd_pkg::CHANNELS_DEF,
    parameter int MAX_DELAY = mlpsmd_pkg::MAX_DELAY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mlpsmd_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [mlpsmd_pkg::CFG_DW-1:0]     cfg_data,
    mlpsmd_in_if.sink                         in_ch,
    mlpsmd_out_if.source                      out_ch
);

    localparam int SW   = mlpsmd_pkg::SW;
    localparam int MW   = mlpsmd_pkg::MW;
    localparam int PW   = mlpsmd_pkg::PW;
    localparam int ACCW = mlpsmd_pkg::ACCW;
    localparam int QW   = mlpsmd_pkg::QW;
    localparam int DENW = mlpsmd_pkg::DENW;
    localparam int TW   = mlpsmd_pkg::TW;
    localparam int WB   = mlpsmd_pkg::WB;
    localparam int WAW  = mlpsmd_pkg::WAW;
    localparam int AW   = $clog2(MAX_DELAY);
    localparam int HID  = mlpsmd_pkg::HIDDEN;

    localparam logic signed [31:0]     ONE_Q   = 32'sd1 <<< mlpsmd_pkg::FRAC;
    localparam logic signed [31:0]     THREE_Q = 32'sd3 <<< mlpsmd_pkg::FRAC;
    localparam logic [DENW-1:0]        C27     = DENW'(27) << mlpsmd_pkg::FRAC;
    localparam logic signed [ACCW-1:0] HALF20  = 64'sd1 <<< 19;
    localparam logic signed [ACCW-1:0] HALF28  = 64'sd1 <<< 27;
    localparam logic signed [PW-1:0]   HALF12  = 56'sd2048;
    localparam logic [12:0]            MIX_ONE = 13'd4096;
    localparam logic signed [SW+20:0]  SMAX    = 45'sd8388607;
    localparam logic signed [SW+20:0]  SMIN    = -45'sd8388608;
    // ceil(2^24 / 3): exact floor division by 3 for operands below 2^23
    localparam logic [MW-1:0]          RECIP3  = 28'd5592406;

    mlpsmd_pkg::state_t state_reg, state_next;
    mlpsmd_pkg::phase_t phase_reg;

    // configuration
    logic [12:0] drive_reg;
    logic [12:0] mix_reg;
    logic [11:0] latency_reg;
    logic        enabled_reg;
    logic [1:0]  chcnt_reg;

    // sequencer counters
    logic [1:0]    lanes_reg;
    logic          lane_reg;
    logic [2:0]    k_reg;
    logic [2:0]    j_reg;
    logic [4:0]    cnt_reg;
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] clr_reg;
    logic          out_valid_reg;

    // datapath
    logic signed [SW-1:0]   samp_reg [mlpsmd_pkg::LANES];
    logic signed [SW-1:0]   res_reg  [mlpsmd_pkg::LANES];
    logic signed [SW-1:0]   out_l_reg, out_r_reg;
    logic signed [SW-1:0]   x_reg;
    logic signed [SW-1:0]   lane_y_reg;
    logic signed [TW-1:0]   dn_reg;
    logic signed [TW-1:0]   tq_reg;
    logic signed [TW-1:0]   h1_reg [HID];
    logic signed [TW-1:0]   h2_reg [HID];
    logic signed [31:0]     a_reg;
    logic signed [SW-1:0]   g_reg;
    logic [DENW-1:0]        c_reg;
    logic [DENW-1:0]        den_reg;
    logic [DENW-1:0]        rem_reg;
    logic [QW-1:0]          dlo_reg;
    logic [QW-1:0]          q_reg;
    logic                   neg_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic [SW-1:0]          lo_reg;
    logic [SW-1:0]          rd_data [mlpsmd_pkg::LANES];

    // combinational
    logic                   in_take;
    logic                   out_free;
    logic [1:0]             lanes_eff;
    logic [AW-1:0]          lag;
    logic [AW-1:0]          rp;
    logic [AW:0]            rp_wrap;
    logic [16:0]            lat_ext;
    logic [12:0]            mix_eff;
    logic [WAW-1:0]         widx_term;
    logic [WAW-1:0]         widx_bias;
    logic signed [WB-1:0]   w_term;
    logic signed [WB-1:0]   w_bias;
    logic signed [MW-1:0]   opnd;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   prod_next;
    logic signed [ACCW-1:0] rnd20, rnd28;
    logic signed [PW-1:0]   rnd12;
    logic signed [SW+20:0]  mix_sum;
    logic signed [SW-1:0]   mix_sat;
    logic [DENW:0]          div_t;
    logic                   div_ge;
    logic signed [TW-1:0]   q_signed;
    logic [2:0]             j_last;
    logic                   more_lanes;
    logic [23:0]            a2w;
    logic signed [PW-1:0]   prod_mag;
    logic signed [SW-1:0]   dnum;
    logic [SW-1:0]          dmag;
    logic [QW-1:0]          dn_q;
    logic [AW-1:0]          wp_inc;
    logic                   ring_clear;
    logic [AW-1:0]          ring_waddr;
    logic [SW-1:0]          ring_wdata;

    assign in_take  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign in_ch.ready      = (state_reg == mlpsmd_pkg::ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.left_out  = out_l_reg;
    assign out_ch.right_out = out_r_reg;

    // clamps and ring addressing
    always_comb
    begin
        lanes_eff = (chcnt_reg > 2'(CHANNELS)) ? 2'(CHANNELS) : chcnt_reg;
        lat_ext   = 17'(latency_reg);
        lag       = (lat_ext > 17'(MAX_DELAY - 1)) ? AW'(MAX_DELAY - 1) : lat_ext[AW-1:0];
        rp_wrap   = {1'b0, wp_reg} + (AW+1)'(MAX_DELAY) - {1'b0, lag};
        rp        = (wp_reg >= lag) ? (wp_reg - lag) : rp_wrap[AW-1:0];
        wp_inc    = (wp_reg == AW'(MAX_DELAY - 1)) ? '0 : wp_reg + 1'b1;
        mix_eff   = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
        more_lanes = (2'({1'b0, lane_reg}) + 2'd1) < lanes_reg;
    end

    // weight addressing and the multiplier operand select
    always_comb
    begin
        widx_term = '0;
        widx_bias = '0;
        opnd      = '0;
        j_last    = 3'(HID - 1);
        case (phase_reg)
            mlpsmd_pkg::PH_L1:
            begin
                widx_term = WAW'(k_reg) * WAW'(mlpsmd_pkg::L1_STRIDE) + WAW'(j_reg);
                widx_bias = WAW'(k_reg) * WAW'(mlpsmd_pkg::L1_STRIDE) + WAW'(2);
                opnd      = (j_reg == 3'd0) ? MW'(x_reg) : MW'(dn_reg);
                j_last    = 3'd1;
            end
            mlpsmd_pkg::PH_L2:
            begin
                widx_term = WAW'(mlpsmd_pkg::L2_BASE)
                          + WAW'(k_reg) * WAW'(mlpsmd_pkg::L2_STRIDE) + WAW'(j_reg);
                widx_bias = WAW'(mlpsmd_pkg::L2_BASE)
                          + WAW'(k_reg) * WAW'(mlpsmd_pkg::L2_STRIDE) + WAW'(HID);
                opnd      = MW'(h1_reg[j_reg]);
            end
            mlpsmd_pkg::PH_OUT:
            begin
                widx_term = WAW'(mlpsmd_pkg::OUT_BASE) + WAW'(j_reg);
                opnd      = MW'(h2_reg[j_reg]);
            end
            default:
            begin
                widx_term = '0;
            end
        endcase
        w_term = mlpsmd_pkg::WROM[widx_term];
        w_bias = mlpsmd_pkg::WROM[widx_bias];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            mlpsmd_pkg::ST_DN_SET:
            begin
                mul_a = MW'(dmag);
                mul_b = MW'(RECIP3);
            end
            mlpsmd_pkg::ST_NEUR_MUL:
            begin
                mul_a = MW'(w_term);
                mul_b = opnd;
            end
            mlpsmd_pkg::ST_TANH:
            begin
                mul_a = a_reg[MW-1:0];
                mul_b = a_reg[MW-1:0];
            end
            mlpsmd_pkg::ST_T_MUL:
            begin
                mul_a = a_reg[MW-1:0];
                mul_b = MW'(c_reg);
            end
            mlpsmd_pkg::ST_G_MUL:
            begin
                mul_a = MW'(x_reg);
                mul_b = MW'(g_reg);
            end
            mlpsmd_pkg::ST_ARG_HI:
            begin
                mul_a = MW'(drive_reg);
                mul_b = {prod_reg[50], prod_reg[50:24]};
            end
            mlpsmd_pkg::ST_ARG_ACC_HI:
            begin
                mul_a = MW'(drive_reg);
                mul_b = MW'(lo_reg);
            end
            mlpsmd_pkg::ST_MIX_MUL:
            begin
                mul_a = MW'(mix_eff);
                mul_b = MW'(tq_reg) - MW'(x_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // rounding, divider step and mix arithmetic
    always_comb
    begin
        rnd20    = (acc_reg + HALF20) >>> 20;
        rnd28    = (acc_reg + HALF28) >>> 28;
        rnd12    = (prod_reg + HALF12) >>> 12;
        mix_sum  = (SW+21)'(x_reg) + rnd12[SW+20:0];
        if (mix_sum > SMAX)
            mix_sat = SMAX[SW-1:0];
        else if (mix_sum < SMIN)
            mix_sat = SMIN[SW-1:0];
        else
            mix_sat = mix_sum[SW-1:0];
        div_t    = {rem_reg, dlo_reg[QW-1]};
        div_ge   = div_t >= {1'b0, den_reg};
        q_signed = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        a2w      = prod_reg[43:20];
        prod_mag = prod_reg[PW-1] ? -prod_reg : prod_reg;
        dnum     = ($signed({11'd0, drive_reg}) - 24'sd256) <<< 9;
        dmag     = (dnum[SW-1] ? SW'(-dnum) : SW'(dnum)) + 1'b1;
        dn_q     = prod_reg[45:24];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlpsmd_pkg::ST_CLEAR:
                if (clr_reg == AW'(MAX_DELAY - 1))
                    state_next = mlpsmd_pkg::ST_IDLE;
            mlpsmd_pkg::ST_IDLE:
                if (in_take)
                begin
                    if (lanes_eff == 2'd0)
                        state_next = mlpsmd_pkg::ST_DONE;
                    else if (enabled_reg)
                        state_next = mlpsmd_pkg::ST_DN_SET;
                    else
                        state_next = mlpsmd_pkg::ST_LANE;
                end
            mlpsmd_pkg::ST_DN_SET:    state_next = mlpsmd_pkg::ST_DIV_END;
            mlpsmd_pkg::ST_DIV:
                if (cnt_reg == 5'(QW - 1))
                    state_next = mlpsmd_pkg::ST_DIV_END;
            mlpsmd_pkg::ST_DIV_END:
                state_next = (phase_reg == mlpsmd_pkg::PH_DN) ? mlpsmd_pkg::ST_LANE
                                                               : mlpsmd_pkg::ST_POST;
            mlpsmd_pkg::ST_LANE:
                state_next = enabled_reg ? mlpsmd_pkg::ST_NEUR_BIAS : mlpsmd_pkg::ST_RING;
            mlpsmd_pkg::ST_NEUR_BIAS: state_next = mlpsmd_pkg::ST_NEUR_MUL;
            mlpsmd_pkg::ST_NEUR_MUL:  state_next = mlpsmd_pkg::ST_NEUR_ACC;
            mlpsmd_pkg::ST_NEUR_ACC:
                state_next = (j_reg == j_last) ? mlpsmd_pkg::ST_NEUR_RND
                                               : mlpsmd_pkg::ST_NEUR_MUL;
            mlpsmd_pkg::ST_NEUR_RND:
                state_next = (phase_reg == mlpsmd_pkg::PH_OUT) ? mlpsmd_pkg::ST_G_MUL
                                                                : mlpsmd_pkg::ST_TANH;
            mlpsmd_pkg::ST_TANH:
                if (a_reg >= THREE_Q || a_reg <= -THREE_Q)
                    state_next = mlpsmd_pkg::ST_POST;
                else
                    state_next = mlpsmd_pkg::ST_T_COEF;
            mlpsmd_pkg::ST_T_COEF:    state_next = mlpsmd_pkg::ST_T_MUL;
            mlpsmd_pkg::ST_T_MUL:     state_next = mlpsmd_pkg::ST_T_DIVSET;
            mlpsmd_pkg::ST_T_DIVSET:  state_next = mlpsmd_pkg::ST_DIV;
            mlpsmd_pkg::ST_POST:
                if (phase_reg == mlpsmd_pkg::PH_Y)
                    state_next = mlpsmd_pkg::ST_MIX_MUL;
                else
                    state_next = mlpsmd_pkg::ST_NEUR_BIAS;
            mlpsmd_pkg::ST_G_MUL:      state_next = mlpsmd_pkg::ST_ARG_HI;
            mlpsmd_pkg::ST_ARG_HI:     state_next = mlpsmd_pkg::ST_ARG_ACC_HI;
            mlpsmd_pkg::ST_ARG_ACC_HI: state_next = mlpsmd_pkg::ST_ARG_ACC_LO;
            mlpsmd_pkg::ST_ARG_ACC_LO: state_next = mlpsmd_pkg::ST_ARG_RND;
            mlpsmd_pkg::ST_ARG_RND:    state_next = mlpsmd_pkg::ST_TANH;
            mlpsmd_pkg::ST_MIX_MUL:    state_next = mlpsmd_pkg::ST_MIX_END;
            mlpsmd_pkg::ST_MIX_END:    state_next = mlpsmd_pkg::ST_RING;
            mlpsmd_pkg::ST_RING:       state_next = mlpsmd_pkg::ST_RING_OUT;
            mlpsmd_pkg::ST_RING_OUT:
                state_next = more_lanes ? mlpsmd_pkg::ST_LANE : mlpsmd_pkg::ST_DONE;
            mlpsmd_pkg::ST_DONE:
                if (out_free)
                    state_next = mlpsmd_pkg::ST_IDLE;
            default:                   state_next = mlpsmd_pkg::ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg   <= 13'd1536;
            mix_reg     <= 13'd4096;
            latency_reg <= '0;
            enabled_reg <= 1'b1;
            chcnt_reg   <= 2'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mlpsmd_pkg::REG_DRIVE:         drive_reg   <= cfg_data;
                mlpsmd_pkg::REG_MIX:           mix_reg     <= cfg_data;
                mlpsmd_pkg::REG_LATENCY:       latency_reg <= cfg_data[11:0];
                mlpsmd_pkg::REG_ENABLED:       enabled_reg <= cfg_data[0];
                mlpsmd_pkg::REG_CHANNEL_COUNT: chcnt_reg   <= cfg_data[1:0];
                default:                       ;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlpsmd_pkg::ST_CLEAR;
            phase_reg     <= mlpsmd_pkg::PH_DN;
            lanes_reg     <= '0;
            lane_reg      <= 1'b0;
            k_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            wp_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // load a finished frame, else drop the taken one
            if (state_reg == mlpsmd_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                mlpsmd_pkg::ST_CLEAR:
                    clr_reg <= clr_reg + 1'b1;
                mlpsmd_pkg::ST_IDLE:
                    if (in_take)
                    begin
                        lanes_reg <= lanes_eff;
                        lane_reg  <= 1'b0;
                        phase_reg <= mlpsmd_pkg::PH_DN;
                    end
                mlpsmd_pkg::ST_T_DIVSET:
                    cnt_reg <= '0;
                mlpsmd_pkg::ST_DIV:
                    cnt_reg <= cnt_reg + 1'b1;
                mlpsmd_pkg::ST_LANE:
                begin
                    phase_reg <= mlpsmd_pkg::PH_L1;
                    k_reg     <= '0;
                end
                mlpsmd_pkg::ST_NEUR_BIAS:
                    j_reg <= '0;
                mlpsmd_pkg::ST_NEUR_ACC:
                    j_reg <= j_reg + 1'b1;
                mlpsmd_pkg::ST_POST:
                    if (phase_reg == mlpsmd_pkg::PH_L1 || phase_reg == mlpsmd_pkg::PH_L2)
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (k_reg == 3'(HID - 1))
                            phase_reg <= (phase_reg == mlpsmd_pkg::PH_L1) ? mlpsmd_pkg::PH_L2
                                                                          : mlpsmd_pkg::PH_OUT;
                    end
                mlpsmd_pkg::ST_ARG_RND:
                    phase_reg <= mlpsmd_pkg::PH_Y;
                mlpsmd_pkg::ST_RING_OUT:
                    if (more_lanes)
                        lane_reg <= 1'b1;
                mlpsmd_pkg::ST_DONE:
                    if (out_free)
                        wp_reg <= wp_inc;
                default:
                    ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (state_reg)
            mlpsmd_pkg::ST_IDLE:
                if (in_take)
                begin
                    samp_reg[0] <= in_ch.left_sample;
                    samp_reg[1] <= in_ch.right_sample;
                    res_reg[0]  <= in_ch.left_sample;
                    res_reg[1]  <= in_ch.right_sample;
                end
            mlpsmd_pkg::ST_DN_SET:
                neg_reg <= dnum[SW-1];
            mlpsmd_pkg::ST_DIV:
            begin
                rem_reg <= div_ge ? DENW'(div_t - {1'b0, den_reg}) : div_t[DENW-1:0];
                q_reg   <= {q_reg[QW-2:0], div_ge};
                dlo_reg <= {dlo_reg[QW-2:0], 1'b0};
            end
            mlpsmd_pkg::ST_DIV_END:
            begin
                tq_reg <= q_signed;
                if (phase_reg == mlpsmd_pkg::PH_DN)
                    dn_reg <= neg_reg ? -$signed({1'b0, dn_q}) : $signed({1'b0, dn_q});
            end
            mlpsmd_pkg::ST_LANE:
            begin
                x_reg      <= samp_reg[lane_reg];
                lane_y_reg <= samp_reg[lane_reg];
            end
            mlpsmd_pkg::ST_NEUR_BIAS:
                acc_reg <= (phase_reg == mlpsmd_pkg::PH_OUT) ? '0
                                                            : ACCW'(w_bias) <<< 20;
            mlpsmd_pkg::ST_NEUR_ACC:
                acc_reg <= acc_reg + ACCW'(prod_reg);
            mlpsmd_pkg::ST_NEUR_RND:
            begin
                a_reg <= rnd20[31:0];
                g_reg <= SW'(ONE_Q) + SW'(rnd20 >>> 1);
            end
            mlpsmd_pkg::ST_TANH:
                if (a_reg >= THREE_Q)
                    tq_reg <= TW'(ONE_Q);
                else if (a_reg <= -THREE_Q)
                    tq_reg <= -TW'(ONE_Q);
            mlpsmd_pkg::ST_T_COEF:
            begin
                c_reg   <= C27 + DENW'(a2w);
                den_reg <= C27 + DENW'({a2w, 3'b000}) + DENW'(a2w);
            end
            mlpsmd_pkg::ST_T_DIVSET:
            begin
                rem_reg <= DENW'(prod_mag[47:22]);
                dlo_reg <= prod_mag[QW-1:0];
                neg_reg <= prod_reg[PW-1];
                q_reg   <= '0;
            end
            mlpsmd_pkg::ST_POST:
                case (phase_reg)
                    mlpsmd_pkg::PH_L1: h1_reg[k_reg] <= tq_reg;
                    mlpsmd_pkg::PH_L2: h2_reg[k_reg] <= tq_reg;
                    default:           ;
                endcase
            mlpsmd_pkg::ST_ARG_HI:
                lo_reg <= prod_reg[SW-1:0];
            mlpsmd_pkg::ST_ARG_ACC_HI:
                acc_reg <= ACCW'(prod_reg) <<< 24;
            mlpsmd_pkg::ST_ARG_ACC_LO:
                acc_reg <= acc_reg + ACCW'(prod_reg);
            mlpsmd_pkg::ST_ARG_RND:
                a_reg <= rnd28[31:0];
            mlpsmd_pkg::ST_MIX_END:
                lane_y_reg <= mix_sat;
            mlpsmd_pkg::ST_RING_OUT:
                res_reg[lane_reg] <= (lag != '0) ? $signed(rd_data[lane_reg]) : lane_y_reg;
            mlpsmd_pkg::ST_DONE:
                if (out_free)
                begin
                    out_l_reg <= res_reg[0];
                    out_r_reg <= res_reg[1];
                end
            default:
                ;
        endcase
    end

    // delay rings, one per configured channel; zero sweep after reset
    assign ring_clear = (state_reg == mlpsmd_pkg::ST_CLEAR);
    assign ring_waddr = ring_clear ? clr_reg : wp_reg;
    assign ring_wdata = ring_clear ? '0 : lane_y_reg;

    for (genvar l = 0; l < mlpsmd_pkg::LANES; l++)
    begin : g_ring
        if (l < CHANNELS)
        begin : g_mem
            logic [SW-1:0] mem [MAX_DELAY];
            logic          we;

            assign we = ring_clear
                     || (state_reg == mlpsmd_pkg::ST_RING && lag != '0
                         && lane_reg == 1'(l));

            always_ff @(posedge clk)
            begin
                if (we)
                    mem[ring_waddr] <= ring_wdata;
                rd_data[l] <= mem[rp];
            end
        end
        else
        begin : g_none
            assign rd_data[l] = '0;
        end
    end

endmodule

[sim/mlp_saturator_mix_delay_test.sv]
// Self-checking testbench for the stereo network saturator with mix and delay ring.
// Depends on mlpsmd_pkg, the channel interfaces and the mlp_saturator_mix_delay top.
module mlp_saturator_mix_delay_test;

    localparam int     RING    = mlpsmd_pkg::MAX_DELAY_DEF;
    localparam int     HID     = mlpsmd_pkg::HIDDEN;
    localparam int     QFRAC   = mlpsmd_pkg::FRAC;
    localparam longint ONE_Q   = 64'sd1 << mlpsmd_pkg::FRAC;
    localparam longint SAT_MAX = 8388607;
    localparam longint SAT_MIN = -8388608;

    typedef logic signed [mlpsmd_pkg::SW-1:0] sample_t;

    typedef struct packed {
        sample_t l;
        sample_t r;
    } frame_t;

    typedef struct {
        int      drv;
        int      mx;
        int      lat;
        int      en;
        int      cc;
        sample_t l;
        sample_t r;
        bit      typed;
        sample_t el;
        sample_t er;
    } row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [mlpsmd_pkg::CFG_IW-1:0]   cfg_index;
    logic [mlpsmd_pkg::CFG_DW-1:0]   cfg_data;

    mlpsmd_in_if  in_ch ();
    mlpsmd_out_if out_ch ();

    mlp_saturator_mix_delay dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // network weights and the modeled block state
    longint  w1 [HID][2];
    longint  b1 [HID];
    longint  w2 [HID][HID];
    longint  b2 [HID];
    longint  w3 [HID];
    sample_t lane_ring [2][RING];
    int      ring_pos;

    int m_drive;
    int m_mix;
    int m_latency;
    int m_enabled;
    int m_lanes;

    frame_t pending_frames [$];
    int     errors;
    int     snd_pct;
    int     rcv_pct;
    int     cur [5];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #80000000;
        $display("** mlp_saturator_mix_delay: FAILED **");
        $finish;
    end

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rshift(longint v, int n);
        return (v + (64'sd1 << (n - 1))) >>> n;
    endfunction

    function automatic void make_weights();
        logic [31:0] s;
        s = 32'h9E3779B9;
        for (int k = 0; k < HID; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                longint n;
                s = s * 32'd1664525 + 32'd1013904223;
                n = longint'(s >> 9) - (64'sd1 << 22);
                if (j < 2)
                    w1[k][j] = rshift(n * 838861, 22);
                else
                    b1[k] = rshift(n * 314573, 22);
            end
        end
        for (int k = 0; k < HID; k++)
        begin
            for (int j = 0; j <= HID; j++)
            begin
                longint n;
                s = s * 32'd1664525 + 32'd1013904223;
                n = longint'(s >> 9) - (64'sd1 << 22);
                if (j < HID)
                    w2[k][j] = rshift(n * 629146, 22);
                else
                    b2[k] = rshift(n * 314573, 22);
            end
        end
        for (int k = 0; k < HID; k++)
        begin
            longint n;
            s = s * 32'd1664525 + 32'd1013904223;
            n = longint'(s >> 9) - (64'sd1 << 22);
            w3[k] = rshift(n * 419430, 22);
        end
    endfunction

    function automatic longint tanh_approx(longint a);
        longint a2;
        if (a >= 3 * ONE_Q)
            return ONE_Q;
        if (a <= -3 * ONE_Q)
            return -ONE_Q;
        a2 = fshift(a * a, QFRAC);
        return (a * (27 * ONE_Q + a2)) / (27 * ONE_Q + 9 * a2);
    endfunction

    function automatic longint saturate_lane(longint x);
        longint h1 [HID];
        longint h2 [HID];
        longint num;
        longint dn;
        longint acc;
        longint g;
        longint y;
        longint m;
        longint o;
        if (m_enabled == 0)
            return x;
        num = (longint'(m_drive) - 256) * 512;
        dn = (num >= 0) ? (num + 1) / 3 : -((-num + 1) / 3);
        for (int k = 0; k < HID; k++)
        begin
            acc = b1[k] * ONE_Q + w1[k][0] * x + w1[k][1] * dn;
            h1[k] = tanh_approx(rshift(acc, QFRAC));
        end
        for (int k = 0; k < HID; k++)
        begin
            acc = b2[k] * ONE_Q;
            for (int j = 0; j < HID; j++)
                acc += w2[k][j] * h1[j];
            h2[k] = tanh_approx(rshift(acc, QFRAC));
        end
        acc = 0;
        for (int k = 0; k < HID; k++)
            acc += w3[k] * h2[k];
        g = ONE_Q + fshift(rshift(acc, QFRAC), 1);
        y = tanh_approx(rshift(longint'(m_drive) * x * g, 28));
        m = (m_mix > 4096) ? 4096 : m_mix;
        o = x + rshift(m * (y - x), 12);
        if (o > SAT_MAX) o = SAT_MAX;
        if (o < SAT_MIN) o = SAT_MIN;
        return o;
    endfunction

    // advance the modeled rings by one frame and return the delayed frame
    function automatic frame_t predict_frame(sample_t l, sample_t r);
        sample_t ins [2];
        sample_t res [2];
        int      lanes;
        int      rp;
        ins[0] = l;
        ins[1] = r;
        res = ins;
        lanes = (m_lanes > 2) ? 2 : m_lanes;
        for (int ch = 0; ch < lanes; ch++)
        begin
            sample_t y;
            y = sample_t'(saturate_lane(longint'(ins[ch])));
            if (m_latency > 0)
            begin
                rp = (ring_pos + RING - m_latency) % RING;
                res[ch] = lane_ring[ch][rp];
                lane_ring[ch][ring_pos] = y;
            end
            else
                res[ch] = y;
        end
        ring_pos = (ring_pos + 1) % RING;
        return '{l: res[0], r: res[1]};
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    task automatic write_reg(mlpsmd_pkg::reg_idx_t idx, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[mlpsmd_pkg::CFG_DW-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            mlpsmd_pkg::REG_DRIVE:         m_drive   = value & 13'h1FFF;
            mlpsmd_pkg::REG_MIX:           m_mix     = value & 13'h1FFF;
            mlpsmd_pkg::REG_LATENCY:       m_latency = value & 12'hFFF;
            mlpsmd_pkg::REG_ENABLED:       m_enabled = value & 1;
            mlpsmd_pkg::REG_CHANNEL_COUNT: m_lanes   = value & 3;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // write only what changed; drain first so the block is idle
    task automatic apply_settings(int drv, int mx, int lat, int en, int cc);
        int want [5];
        want = '{drv, mx, lat, en, cc};
        if (want == cur)
            return;
        drain();
        for (int i = 0; i < 5; i++)
            if (want[i] != cur[i])
                write_reg(mlpsmd_pkg::reg_idx_t'(i), want[i]);
        cur = want;
    endtask

    task automatic send_frame(sample_t l, sample_t r, bit typed, sample_t el, sample_t er);
        frame_t p;
        while (roll(snd_pct))
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.left_sample  = l;
        in_ch.right_sample = r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        p = predict_frame(l, r);
        if (typed)
            p = '{l: el, r: er};
        pending_frames.push_back(p);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // result side: ready changes at the falling edge, checked at the rising edge
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = !roll(rcv_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected result %h %h", $time, out_ch.left_out,
                         out_ch.right_out);
                errors++;
            end
            else
            begin
                frame_t e;
                e = pending_frames.pop_front();
                if (out_ch.left_out !== e.l)
                begin
                    $display("%0t: left_out expected %0d got %0d", $time, e.l,
                             out_ch.left_out);
                    errors++;
                end
                if (out_ch.right_out !== e.r)
                begin
                    $display("%0t: right_out expected %0d got %0d", $time, e.r,
                             out_ch.right_out);
                    errors++;
                end
            end
        end
    end

    function automatic sample_t rand_sample();
        case ($urandom_range(5, 0))
            0:       return sample_t'($urandom);
            1:       return $urandom_range(1) ? sample_t'(SAT_MAX) : sample_t'(SAT_MIN);
            2:       return sample_t'($signed($urandom_range(200, 0)) - 100);
            default: return sample_t'($signed($urandom_range(6291456, 0)) - 3145728);
        endcase
    endfunction

    row_t dir_rows [$];
    localparam sample_t PMAX = 24'sh7FFFFF;
    localparam sample_t NMIN = 24'sh800000;

    initial
    begin
        make_weights();
        errors    = 0;
        ring_pos  = 0;
        snd_pct   = 0;
        rcv_pct   = 0;
        m_drive   = 1536;
        m_mix     = 4096;
        m_latency = 0;
        m_enabled = 1;
        m_lanes   = 2;
        cur       = '{1536, 4096, 0, 1, 2};
        for (int c = 0; c < 2; c++)
            for (int i = 0; i < RING; i++)
                lane_ring[c][i] = '0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.left_sample  = '0;
        in_ch.right_sample = '0;

        // drive, mix, latency, enabled, lanes, left, right, typed, expected
        dir_rows = '{
            '{1536, 4096, 0, 1, 2, 0, 0, 1, 0, 0},
            '{1536, 4096, 0, 1, 2, PMAX, NMIN, 0, 0, 0},
            '{1536, 4096, 0, 1, 2, 24'sd1048576, -24'sd1, 0, 0, 0},
            '{1536, 4096, 0, 0, 2, PMAX, NMIN, 1, PMAX, NMIN},
            '{1536, 4096, 0, 1, 0, NMIN, PMAX, 1, NMIN, PMAX},
            '{1536, 4096, 0, 1, 1, 24'sd300000, PMAX, 0, 0, 0},
            '{1536, 4096, 0, 1, 3, 24'sd300000, -24'sd300000, 0, 0, 0},
            '{1536, 8191, 0, 1, 2, 24'sd500000, -24'sd2000000, 0, 0, 0},
            '{1536, 0, 0, 1, 2, 24'sd777, NMIN, 1, 24'sd777, NMIN},
            '{0, 2048, 0, 1, 2, 24'sd900000, -24'sd900000, 0, 0, 0},
            '{8191, 4096, 0, 1, 2, 24'sd1000, NMIN, 0, 0, 0},
            '{256, 4096, 0, 1, 2, 24'sd2000000, -24'sd5, 0, 0, 0},
            '{6400, 4096, 0, 1, 2, -24'sd123456, PMAX, 0, 0, 0},
            '{1536, 4096, 3, 1, 2, 24'sd100000, 24'sd200000, 1, 0, 0},
            '{1536, 4096, 3, 1, 2, -24'sd100000, -24'sd200000, 1, 0, 0},
            '{1536, 4096, 3, 1, 2, PMAX, NMIN, 1, 0, 0},
            '{1536, 4096, 3, 1, 2, 24'sd5, 24'sd6, 0, 0, 0},
            '{1536, 4096, 3, 1, 1, 24'sd7, 24'sd8, 0, 0, 0},
            '{1536, 4096, 3, 0, 2, 24'sd9, 24'sd10, 0, 0, 0},
            '{1536, 4096, 4095, 1, 2, 24'sd11, 24'sd12, 0, 0, 0},
            '{1536, 4096, 4095, 0, 0, 24'sd13, 24'sd14, 1, 24'sd13, 24'sd14}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            apply_settings(dir_rows[i].drv, dir_rows[i].mx, dir_rows[i].lat,
                           dir_rows[i].en, dir_rows[i].cc);
            send_frame(dir_rows[i].l, dir_rows[i].r, dir_rows[i].typed,
                       dir_rows[i].el, dir_rows[i].er);
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            int drv;
            int mx;
            int lat;
            int en;
            int cc;
            drv = (ph % 3 == 0) ? ((ph % 2) ? 6400 : 256) : $urandom_range(8191, 0);
            mx  = (ph % 4 == 1) ? 0 : ((ph % 5 == 2) ? 8191 : $urandom_range(4096, 0));
            case (ph % 4)
                0:       lat = 0;
                1:       lat = $urandom_range(20, 1);
                2:       lat = 4095;
                default: lat = $urandom_range(4095, 0);
            endcase
            en = (ph % 3 == 2) ? 0 : 1;
            cc = (ph % 6 == 4) ? $urandom_range(1, 0) : ((ph == 7) ? 3 : 2);
            apply_settings(drv, mx, lat, en, cc);
            case (ph % 4)
                0:       begin snd_pct = 0;  rcv_pct = 0;  end
                1:       begin snd_pct = 84; rcv_pct = 0;  end
                2:       begin snd_pct = 0;  rcv_pct = 84; end
                default: begin snd_pct = 15; rcv_pct = 15; end
            endcase
            for (int n = 0; n < 140; n++)
            begin
                // hold the sender until every pending result is back
                if (ph == 5 && n == 70)
                    while (pending_frames.size() != 0)
                        @(negedge clk);
                send_frame(rand_sample(), rand_sample(), 0, '0, '0);
            end
        end

        snd_pct = 0;
        rcv_pct = 0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (3000) @(negedge clk);
        if (errors == 0)
            $display("** mlp_saturator_mix_delay: PASSED **");
        else
            $display("** mlp_saturator_mix_delay: FAILED **");
        $finish;
    end

endmodule
